>>> hw/rtl/tblu_pkg.sv
// ----------------------------------------------------------------------------
// tblu_pkg
// Shared types and constants of the threshold boundary labeler: payload
// structs, label and command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tblu_pkg;

    // default frame limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // configuration register widths
    localparam int THRESHOLD_W  = 9;
    localparam int IMG_WIDTH_W  = 12;
    localparam int IMG_HEIGHT_W = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    // result field widths
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 11;

    // result queue depth
    localparam int OUT_QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET  = 9'd128;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 12'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 13'd480;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // input commands
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } command_t;

    // pixel labels
    typedef enum logic [1:0] {
        LABEL_BACKGROUND = 2'd0,
        LABEL_BOUNDARY   = 2'd1,
        LABEL_INTERIOR   = 2'd2
    } label_t;

    typedef struct packed {
        command_t    command;
        logic [7:0]  pixel;
    } in_item_t;

    typedef struct packed {
        label_t                label;
        logic [OUT_ROW_W-1:0]  out_row;
        logic [OUT_COL_W-1:0]  out_col;
        logic                  end_of_frame;
    } out_item_t;

    // one result produced by the labeling logic in a cycle
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_slot_t;

endpackage

>>> hw/rtl/tblu_ram.sv
// ----------------------------------------------------------------------------
// tblu_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module tblu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/tblu_out_queue.sv
// ----------------------------------------------------------------------------
// tblu_out_queue
// Small result queue between the labeling logic and the output channel.
// Takes up to two results per cycle, hands out one per accepted request.
// ----------------------------------------------------------------------------
module tblu_out_queue #(
    parameter int DEPTH = tblu_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tblu_pkg::result_slot_t slot_a,
    input  tblu_pkg::result_slot_t slot_b,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tblu_pkg::out_item_t    out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    tblu_pkg::out_item_t entry_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic [PW-1:0] pos_b;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (32'(p) == DEPTH - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // room for a full pair of results
    assign space     = 32'(count_reg) <= DEPTH - 2;
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // second result lands behind the first one if there is one
    assign pos_b = slot_a.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (slot_a.valid)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (slot_b.valid)
        begin
            wr_ptr_next = ptr_inc(pos_b);
        end
        if (pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        count_next = count_reg + NW'(slot_a.valid) + NW'(slot_b.valid) - NW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (slot_a.valid)
        begin
            entry_reg[wr_ptr_reg] <= slot_a.item;
        end
        if (slot_b.valid)
        begin
            entry_reg[pos_b] <= slot_b.item;
        end
    end

endmodule

>>> hw/rtl/threshold_boundary_labeler_unit.sv
// ----------------------------------------------------------------------------
// threshold_boundary_labeler_unit
// Thresholds a raster-order grayscale stream and labels each pixel as
// background, boundary or interior from its 3x3 neighborhood.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request per cycle while in_ready is high: a
//   pixel (command 0) or a drain request (command 1). out_valid/out_ready carry
//   labels in raster order with row, column and an end-of-frame flag on the last pixel.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Throughput and ordering:
//   One request per cycle while in_ready is high. The label of pixel (r,c)
//   is computed when pixel (r+1,c+1) is accepted and is registered in the
//   result queue; a row's last label comes in the same cycle. The final row
//   is released one label per drain request. The row store RAM has a
//   registered read, so the column the next request needs is prefetched one column ahead.
// Stalls:
//   Results wait in a four-entry queue; in_ready stays high while the queue
//   has room for two results, so input keeps flowing when the receiver is
//   briefly stalled and stops once the queue is nearly full.
// Reset:
//   Registers return to defaults (threshold 128, 640 x 480), position
//   counters and the queue clear. The row store is not cleared: the first row
//   of a frame never reads it.
// ----------------------------------------------------------------------------
module threshold_boundary_labeler_unit #(
    parameter int MAX_WIDTH  = tblu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tblu_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tblu_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tblu_pkg::out_item_t              out_data,
    input  logic                             cfg_write,
    input  logic [tblu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tblu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int ORW = tblu_pkg::OUT_ROW_W;
    localparam int OCW = tblu_pkg::OUT_COL_W;

    // configuration registers
    logic [tblu_pkg::THRESHOLD_W-1:0]  threshold_reg;
    logic [tblu_pkg::IMG_WIDTH_W-1:0]  image_width_reg;
    logic [tblu_pkg::IMG_HEIGHT_W-1:0] image_height_reg;

    // position and window state
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [WW-1:0] drain_col_reg, drain_col_next;
    logic [8:0]    window_reg, window_next;
    logic [2:0]    first_col_reg, first_col_next;
    logic [2:0]    dleft_reg, dleft_next;
    logic [2:0]    dmid_reg, dmid_next;
    logic          fwd_valid_reg, fwd_valid_next;
    logic [2:0]    fwd_data_reg, fwd_data_next;

    // row store port
    logic          ram_we;
    logic [CW-1:0] ram_wr_addr;
    logic [2:0]    ram_wr_data;
    logic [CW-1:0] ram_rd_addr;
    logic [2:0]    ram_rd_data;

    logic [WW-1:0] eff_width;
    logic [HW-1:0] eff_height;
    logic [31:0]   width_ext, height_ext;

    logic          accept, draining, pix_go, drn_go;
    logic [2:0]    store_rd;
    logic          fg, row_first, last_col, last_row;
    logic [2:0]    col_bits;
    logic [8:0]    win_new;
    logic [RW-1:0] row_prev;
    logic [WW-1:0] d;
    logic          lastd, mid_in, left_in;
    logic [2:0]    col_l, col_m, col_r;
    logic [8:0]    drain_win;

    tblu_pkg::result_slot_t slot_a, slot_b;

    function automatic tblu_pkg::label_t classify(input logic [8:0] win);
        logic [8:0]        nb;
        logic [3:0]        n;
        tblu_pkg::label_t  lab;
        nb = win & 9'h1EF;
        n  = '0;
        for (int i = 0; i < 9; i++)
        begin
            n = n + 4'(nb[i]);
        end
        if (!win[4])
        begin
            lab = tblu_pkg::LABEL_BACKGROUND;
        end
        else if (n != 4'd0 && n < 4'd8)
        begin
            lab = tblu_pkg::LABEL_BOUNDARY;
        end
        else
        begin
            lab = tblu_pkg::LABEL_INTERIOR;
        end
        return lab;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= tblu_pkg::THRESHOLD_RESET;
            image_width_reg  <= tblu_pkg::IMG_WIDTH_RESET;
            image_height_reg <= tblu_pkg::IMG_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tblu_pkg::REG_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[tblu_pkg::THRESHOLD_W-1:0];
                end
                tblu_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[tblu_pkg::IMG_WIDTH_W-1:0];
                end
                tblu_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[tblu_pkg::IMG_HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame size clamped to 1..max
    assign width_ext  = 32'(image_width_reg);
    assign height_ext = 32'(image_height_reg);
    assign eff_width  = (width_ext == 32'd0) ? WW'(1) :
                        (width_ext > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
    assign eff_height = (height_ext == 32'd0) ? HW'(1) :
                        (height_ext > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);

    // request decode
    assign accept   = in_valid && in_ready;
    assign draining = drain_col_reg != '0;
    assign pix_go   = accept && !draining && (in_data.command == tblu_pkg::CMD_PIXEL);
    assign drn_go   = accept && draining && (in_data.command == tblu_pkg::CMD_DRAIN);

    // store column, bypassed when it was written in the cycle before
    assign store_rd = fwd_valid_reg ? fwd_data_reg : ram_rd_data;

    // pixel path: new column of three rows and the shifted window
    assign fg        = {1'b0, in_data.pixel} >= threshold_reg;
    assign row_first = cur_row_reg == '0;
    assign col_bits  = row_first ? {2'b00, fg} : {store_rd[1:0], fg};
    assign win_new   = (cur_col_reg == '0) ? {6'b0, col_bits} : {window_reg[5:0], col_bits};
    assign last_col  = 32'(cur_col_reg) + 32'd1 >= 32'(eff_width);
    assign last_row  = 32'(cur_row_reg) + 32'd1 >= 32'(eff_height);
    assign row_prev  = cur_row_reg - 1'b1;

    // drain path: final row with background below, masked past the row end
    assign d         = drain_col_reg - 1'b1;
    assign lastd     = 32'(d) + 32'd1 >= 32'(eff_width);
    assign mid_in    = 32'(d) < 32'(eff_width);
    assign left_in   = (d != '0) && (32'(d) <= 32'(eff_width));
    assign col_l     = left_in ? {dleft_reg[1:0], 1'b0} : 3'b000;
    assign col_m     = mid_in ? {dmid_reg[1:0], 1'b0} : 3'b000;
    assign col_r     = lastd ? 3'b000 : {store_rd[1:0], 1'b0};
    assign drain_win = {col_l, col_m, col_r};

    // results of this request
    always_comb
    begin
        slot_a = '0;
        slot_b = '0;
        if (drn_go)
        begin
            slot_a.valid             = 1'b1;
            slot_a.item.label        = classify(drain_win);
            slot_a.item.out_row      = ORW'(32'(cur_row_reg));
            slot_a.item.out_col      = OCW'(32'(d));
            slot_a.item.end_of_frame = lastd;
        end
        else
        begin
            slot_a.valid             = pix_go && !row_first && (cur_col_reg != '0);
            slot_a.item.label        = classify(win_new);
            slot_a.item.out_row      = ORW'(32'(row_prev));
            slot_a.item.out_col      = OCW'(32'(cur_col_reg - 1'b1));
            slot_a.item.end_of_frame = 1'b0;
        end
        slot_b.valid             = pix_go && !row_first && last_col;
        slot_b.item.label        = classify({win_new[5:0], 3'b000});
        slot_b.item.out_row      = ORW'(32'(row_prev));
        slot_b.item.out_col      = OCW'(32'(cur_col_reg));
        slot_b.item.end_of_frame = 1'b0;
    end

    // next state and row store access
    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        drain_col_next = drain_col_reg;
        window_next    = window_reg;
        first_col_next = first_col_reg;
        dleft_next     = dleft_reg;
        dmid_next      = dmid_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = cur_col_reg;
        ram_wr_data    = col_bits;
        if (pix_go)
        begin
            ram_we      = 1'b1;
            window_next = win_new;
            if (cur_col_reg == '0)
            begin
                first_col_next = col_bits;
            end
            if (last_col)
            begin
                cur_col_next = '0;
                if (last_row)
                begin
                    drain_col_next = WW'(1);
                    dleft_next     = 3'b000;
                    dmid_next      = (cur_col_reg == '0) ? col_bits : first_col_reg;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            else
            begin
                cur_col_next = cur_col_reg + 1'b1;
            end
        end
        else if (drn_go)
        begin
            if (lastd)
            begin
                cur_row_next   = '0;
                cur_col_next   = '0;
                drain_col_next = '0;
                window_next    = '0;
            end
            else
            begin
                drain_col_next = drain_col_reg + 1'b1;
                dleft_next     = dmid_reg;
                dmid_next      = store_rd;
            end
        end
        // prefetch the column the next request needs
        if (drain_col_next != '0)
        begin
            ram_rd_addr = drain_col_next[CW-1:0];
        end
        else
        begin
            ram_rd_addr = cur_col_next;
        end
        fwd_valid_next = ram_we && (ram_wr_addr == ram_rd_addr);
        fwd_data_next  = ram_wr_data;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            drain_col_reg <= '0;
            window_reg    <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            drain_col_reg <= drain_col_next;
            window_reg    <= window_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // column data registers
    always_ff @(posedge clk)
    begin
        first_col_reg <= first_col_next;
        dleft_reg     <= dleft_next;
        dmid_reg      <= dmid_next;
        fwd_data_reg  <= fwd_data_next;
    end

    // three rows of foreground bits per column
    tblu_ram #(
        .WIDTH (3),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result queue
    tblu_out_queue #(
        .DEPTH (tblu_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot_a    (slot_a),
        .slot_b    (slot_b),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // drain always starts from column zero of the position counter
    a_drain_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_col_reg != '0) |-> (cur_col_reg == '0))
        else $error("column counter not zero while draining");

    // the last drain request returns the block to the start of a frame
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (drn_go && lastd) |=> (drain_col_reg == '0 && cur_row_reg == '0 &&
                               cur_col_reg == '0))
        else $error("counters not cleared after final drain");

    // a lone row-end result only happens in the first column
    a_lone_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_b.valid && !slot_a.valid) |-> (cur_col_reg == '0))
        else $error("row-end label without a preceding label");

endmodule

>>> test/tblu_label_checker.sv
// ----------------------------------------------------------------------------
// tblu_label_checker
// Watches the request, label and register channels of the threshold boundary
// labeler, keeps its own copy of the row history and the 3x3 window, predicts
// the labels of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tblu_label_checker #(
    parameter int MAX_WIDTH  = tblu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tblu_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  tblu_pkg::in_item_t               in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  tblu_pkg::out_item_t              out_data,
    input  logic                             cfg_write,
    input  logic [tblu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tblu_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_count,
    output int                               labels_pending
);

    // register copies
    logic [tblu_pkg::THRESHOLD_W-1:0]  threshold_reg;
    logic [tblu_pkg::IMG_WIDTH_W-1:0]  width_reg;
    logic [tblu_pkg::IMG_HEIGHT_W-1:0] height_reg;

    // foreground history per column: bit 0 newest row, bits 1 and 2 above it
    logic [2:0] fg_history [MAX_WIDTH];

    // raster position and drain progress (0 while pixels are taken)
    int row_pos;
    int col_pos;
    int drain_pos;

    // three columns of the neighborhood, left column in the high bits
    logic [8:0] nbhd;

    tblu_pkg::out_item_t pending_labels [$];

    // label of the center of a 3x3 neighborhood
    function automatic tblu_pkg::label_t window_label(input logic [8:0] win);
        int n;
        if (!win[4])
            return tblu_pkg::LABEL_BACKGROUND;
        n = $countones(win & 9'h1EF);
        return (n > 0 && n < 8) ? tblu_pkg::LABEL_BOUNDARY : tblu_pkg::LABEL_INTERIOR;
    endfunction

    // stored column with a background row below it, for the last row
    function automatic logic [2:0] drain_bits(input int x, input int w);
        if (x >= w || x >= MAX_WIDTH)
            return 3'b000;
        return {fg_history[x][1:0], 1'b0};
    endfunction

    task automatic push_label(input tblu_pkg::label_t lab, input int row, input int col,
                              input logic eof);
        tblu_pkg::out_item_t item;
        item.label        = lab;
        item.out_row      = tblu_pkg::OUT_ROW_W'(row);
        item.out_col      = tblu_pkg::OUT_COL_W'(col);
        item.end_of_frame = eof;
        pending_labels.push_back(item);
    endtask

    // advance the frame by one request and queue the labels it releases
    task automatic label_request(input tblu_pkg::in_item_t req);
        int         w;
        int         h;
        int         r;
        int         c;
        int         d;
        logic       fg;
        logic       last;
        logic [2:0] col;
        logic [8:0] win;
        w = int'(width_reg);
        h = int'(height_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h < 1)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;

        if (drain_pos == 0)
        begin
            // drain request while pixels are due is dropped
            if (req.command != tblu_pkg::CMD_PIXEL)
                return;
            r = row_pos;
            c = col_pos;
            if (c >= MAX_WIDTH)
                c = MAX_WIDTH - 1;
            fg  = ({1'b0, req.pixel} >= threshold_reg);
            col = (r == 0) ? {2'b00, fg} : {fg_history[c][1:0], fg};
            fg_history[c] = col;
            nbhd = (c == 0) ? {6'b000000, col} : {nbhd[5:0], col};
            last = (c + 1 >= w);
            if (r >= 1)
            begin
                if (c >= 1)
                    push_label(window_label(nbhd), r - 1, c - 1, 1'b0);
                // right edge: the row's last label follows at once
                if (last)
                    push_label(window_label({nbhd[5:0], 3'b000}), r - 1, c, 1'b0);
            end
            if (last)
            begin
                col_pos = 0;
                if (r + 1 >= h)
                    drain_pos = 1;
                else
                    row_pos = r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        end
        else
        begin
            // pixel request while draining is dropped
            if (req.command != tblu_pkg::CMD_DRAIN)
                return;
            d    = drain_pos - 1;
            last = (d + 1 >= w);
            win  = {(d >= 1) ? drain_bits(d - 1, w) : 3'b000,
                    drain_bits(d, w),
                    last ? 3'b000 : drain_bits(d + 1, w)};
            push_label(window_label(win), row_pos, d, last);
            if (last)
            begin
                row_pos   = 0;
                col_pos   = 0;
                drain_pos = 0;
                nbhd      = '0;
            end
            else
            begin
                drain_pos = drain_pos + 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 200)
            $display("[%0t] label mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // compare one accepted label with the oldest prediction
    task automatic check_label(input tblu_pkg::out_item_t got);
        tblu_pkg::out_item_t want;
        if (pending_labels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected label %0d at row %0d col %0d",
                                      got.label, got.out_row, got.out_col));
            return;
        end
        want = pending_labels.pop_front();
        if (got.label !== want.label)
            report_mismatch($sformatf("row %0d col %0d: label %0d, want %0d",
                                      want.out_row, want.out_col, got.label, want.label));
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("row %0d col %0d: out_row %0d",
                                      want.out_row, want.out_col, got.out_row));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("row %0d col %0d: out_col %0d",
                                      want.out_row, want.out_col, got.out_col));
        if (got.end_of_frame !== want.end_of_frame)
            report_mismatch($sformatf("row %0d col %0d: end_of_frame %0b, want %0b",
                                      want.out_row, want.out_col,
                                      got.end_of_frame, want.end_of_frame));
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg = tblu_pkg::THRESHOLD_RESET;
            width_reg     = tblu_pkg::IMG_WIDTH_RESET;
            height_reg    = tblu_pkg::IMG_HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
                fg_history[i] = 3'b000;
            row_pos        = 0;
            col_pos        = 0;
            drain_pos      = 0;
            nbhd           = '0;
            mismatch_count = 0;
            pending_labels.delete();
            labels_pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (tblu_pkg::cfg_reg_t'(cfg_index))
                    tblu_pkg::REG_THRESHOLD:
                        threshold_reg = cfg_data[tblu_pkg::THRESHOLD_W-1:0];
                    tblu_pkg::REG_IMAGE_WIDTH:
                        width_reg     = cfg_data[tblu_pkg::IMG_WIDTH_W-1:0];
                    tblu_pkg::REG_IMAGE_HEIGHT:
                        height_reg    = cfg_data[tblu_pkg::IMG_HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                label_request(in_data);
            if (out_valid && out_ready)
                check_label(out_data);
            // updated after the edge so the stimulus always sees a settled count
            labels_pending <= pending_labels.size();
        end
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the threshold boundary labeler with small directed frames, then
// random frames under several settings and idle patterns, with a label
// checker beside the block and a watchdog on handshake progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1650;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    tblu_pkg::in_item_t               in_data;
    logic                             out_valid;
    logic                             out_ready;
    tblu_pkg::out_item_t              out_data;
    logic                             cfg_write;
    logic [tblu_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tblu_pkg::CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int labels_pending;

    // traffic shaping
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    // current frame setup as seen by the stimulus
    int thr_now;
    int frame_w;
    int frame_h;
    int frame_items = 0;

    int stall_cycles;

    always #5 clk = ~clk;

    threshold_boundary_labeler_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tblu_label_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .labels_pending (labels_pending)
    );

    // offer one request and hold it until accepted
    task automatic send_req(input tblu_pkg::command_t cmd, input logic [7:0] pix);
        tblu_pkg::in_item_t item;
        item.command = cmd;
        item.pixel   = pix;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering, let all labels drain, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (labels_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input tblu_pkg::cfg_reg_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tblu_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int thr, input int w, input int h);
        wait_idle();
        write_reg(tblu_pkg::REG_THRESHOLD, thr);
        write_reg(tblu_pkg::REG_IMAGE_WIDTH, w);
        write_reg(tblu_pkg::REG_IMAGE_HEIGHT, h);
        thr_now = thr;
        frame_w = (w < 1) ? 1 : (w > tblu_pkg::MAX_WIDTH_DEF) ? tblu_pkg::MAX_WIDTH_DEF : w;
        frame_h = (h < 1) ? 1 : (h > tblu_pkg::MAX_HEIGHT_DEF) ? tblu_pkg::MAX_HEIGHT_DEF : h;
    endtask

    // pixel on the chosen side of the threshold, or uniform
    function automatic logic [7:0] pick_pixel(input int fg_pct, input logic uniform);
        if (uniform || thr_now == 0 || thr_now > 255)
            return 8'($urandom_range(255));
        if ($urandom_range(99) < fg_pct)
            return 8'($urandom_range(255, thr_now));
        return 8'($urandom_range(thr_now - 1, 0));
    endfunction

    // one whole frame plus its drain, with stray requests mixed in
    task automatic send_frame(input int fg_pct, input logic uniform, input int noise_pct);
        int i;
        for (i = 0; i < frame_w * frame_h; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_req(tblu_pkg::CMD_DRAIN, 8'($urandom));
            send_req(tblu_pkg::CMD_PIXEL, pick_pixel(fg_pct, uniform));
        end
        for (i = 0; i < frame_w; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_req(tblu_pkg::CMD_PIXEL, 8'($urandom));
            send_req(tblu_pkg::CMD_DRAIN, 8'($urandom));
        end
        frame_items += frame_w * frame_h + frame_w;
    endtask

    task automatic random_frame();
        int thr;
        int w;
        int h;
        int sel;
        if ($urandom_range(99) < 70)
        begin
            sel = $urandom_range(9);
            thr = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(511, 256)
                                              : $urandom_range(255, 1);
            sel = $urandom_range(9);
            w   = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(40, 17)
                                              : $urandom_range(16, 1);
            sel = $urandom_range(9);
            h   = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(12, 9)
                                              : $urandom_range(8, 1);
            configure(thr, w, h);
        end
        sel = $urandom_range(4);
        case (sel)
            0:       send_frame(0, 1'b1, 4);
            1:       send_frame(15, 1'b0, 4);
            2:       send_frame(60, 1'b0, 4);
            3:       send_frame(92, 1'b0, 4);
            default: send_frame(100, 1'b0, 4);
        endcase
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin : receiver
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on handshake progress
    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int phase;
        int phase_start;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small frame, stray request on either side, pixel extremes
        configure(100, 3, 2);
        send_req(tblu_pkg::CMD_DRAIN, 8'hA5);
        send_req(tblu_pkg::CMD_PIXEL, 8'd0);
        send_req(tblu_pkg::CMD_PIXEL, 8'd255);
        send_req(tblu_pkg::CMD_PIXEL, 8'd100);
        send_req(tblu_pkg::CMD_PIXEL, 8'd99);
        send_req(tblu_pkg::CMD_PIXEL, 8'd255);
        send_req(tblu_pkg::CMD_PIXEL, 8'd128);
        send_req(tblu_pkg::CMD_PIXEL, 8'h5A);
        send_req(tblu_pkg::CMD_DRAIN, 8'hFF);
        send_req(tblu_pkg::CMD_DRAIN, 8'h00);
        send_req(tblu_pkg::CMD_DRAIN, 8'h3C);

        // threshold above 255, zero width and height: one-row 1x1 frame
        configure(256, 0, 0);
        send_req(tblu_pkg::CMD_PIXEL, 8'hFF);
        send_req(tblu_pkg::CMD_DRAIN, 8'h00);

        // threshold zero: lone foreground pixel stays interior
        configure(0, 1, 1);
        send_req(tblu_pkg::CMD_PIXEL, 8'h00);
        send_req(tblu_pkg::CMD_DRAIN, 8'hFF);

        // width and height shrink in mid-frame, past the current column
        configure(128, 4, 4);
        for (i = 0; i < 10; i++)
            send_req(tblu_pkg::CMD_PIXEL, 8'(i * 29));
        wait_idle();
        write_reg(tblu_pkg::REG_IMAGE_WIDTH, 2);
        write_reg(tblu_pkg::REG_IMAGE_HEIGHT, 3);
        send_req(tblu_pkg::CMD_PIXEL, 8'd200);
        send_req(tblu_pkg::CMD_DRAIN, 8'h81);
        send_req(tblu_pkg::CMD_DRAIN, 8'h7E);

        // random frames under four idle patterns
        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_start = frame_items;

            if (phase == 0)
            begin
                // receiver holds off while requests keep coming
                configure(128, 16, 6);
                hold_off_cycles = HOLD_CYCLES;
                send_frame(60, 1'b0, 0);
            end

            while (frame_items - phase_start < RANDOM_ITEMS / 4)
                random_frame();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && labels_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tblu_pkg.sv
hw/rtl/tblu_ram.sv
hw/rtl/tblu_out_queue.sv
hw/rtl/threshold_boundary_labeler_unit.sv
test/tblu_label_checker.sv
test/tb_top.sv
